### rtl/rtfnc_pkg.sv
// Shared constants, control types and the half-tanh table for the radio tone block.
`default_nettype none

package rtfnc_pkg;

	// Sample format and table size
	localparam int TANH_TABLE_DEPTH = 256;
	localparam int SAMPLE_BITS      = 16;
	localparam int FRAC_BITS        = SAMPLE_BITS - 1;

	// Register and state widths
	localparam int COEF_W    = 16;
	localparam int ACC_W     = 24;
	localparam int LFSR_W    = 16;
	localparam int CFG_IDX_W = 8;

	localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

	localparam logic [COEF_W-1:0] LP_COEF_RST    = 16'd42743;
	localparam logic [COEF_W-1:0] HP_COEF_RST    = 16'd62794;
	localparam logic [COEF_W-1:0] NOISE_LVL_RST  = 16'd3277;
	localparam logic [COEF_W-1:0] NOISE_SEED_RST = 16'd44257;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LP_COEF    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HP_COEF    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_LVL  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_SEED = 8'd3;

	// Datapath widths
	localparam int DIFF_W   = ACC_W + 2;
	localparam int NOISE_SH = 31 - FRAC_BITS;
	localparam int NOISE_W  = 34 - NOISE_SH;
	localparam int T_W      = ((ACC_W > NOISE_W) ? ACC_W : NOISE_W) + 2;
	localparam int MAG_W    = FRAC_BITS + 3;
	localparam int FRAC_W   = FRAC_BITS + 2;
	localparam int MUL_A_W  = (DIFF_W > MAG_W + 1) ? DIFF_W : MAG_W + 1;
	localparam int MUL_B_W  = (COEF_W + 2 > FRAC_BITS + 1) ? COEF_W + 2 : FRAC_BITS + 1;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;
	localparam int SUM_W    = PROD_W + 1;
	localparam int IDX_W    = $clog2(TANH_TABLE_DEPTH + 1);
	localparam int TAB_W    = FRAC_BITS;

	// Micro-operations
	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_NOP     = 5'd0;
	localparam logic [OP_W-1:0] OP_LOAD    = 5'd1;
	localparam logic [OP_W-1:0] OP_LP_MUL1 = 5'd2;
	localparam logic [OP_W-1:0] OP_LP_MUL2 = 5'd3;
	localparam logic [OP_W-1:0] OP_LP_WB   = 5'd4;
	localparam logic [OP_W-1:0] OP_DIFF    = 5'd5;
	localparam logic [OP_W-1:0] OP_HP_MUL  = 5'd6;
	localparam logic [OP_W-1:0] OP_HP_WB   = 5'd7;
	localparam logic [OP_W-1:0] OP_NZ_MUL  = 5'd8;
	localparam logic [OP_W-1:0] OP_NZ_WB   = 5'd9;
	localparam logic [OP_W-1:0] OP_MAG     = 5'd10;
	localparam logic [OP_W-1:0] OP_IDX_MUL = 5'd11;
	localparam logic [OP_W-1:0] OP_IDX_WB  = 5'd12;
	localparam logic [OP_W-1:0] OP_RD_LO   = 5'd13;
	localparam logic [OP_W-1:0] OP_RD_HI   = 5'd14;
	localparam logic [OP_W-1:0] OP_INT_MUL = 5'd15;
	localparam logic [OP_W-1:0] OP_RD_TOP  = 5'd16;
	localparam logic [OP_W-1:0] OP_EMIT    = 5'd17;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            en;
	} ctrl_t;

	typedef struct packed {
		logic top;
		logic out_free;
	} stat_t;

	typedef logic [TAB_W-1:0] tab_t [TANH_TABLE_DEPTH+1];

	// Restoring division, elaboration only
	function automatic longint unsigned udiv64(input longint unsigned num,
			input longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = 64'd0;
		r = 64'd0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], num[i]};
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 64'd1;
			end
		end
		return q;
	endfunction

	// Entry i = round(2^(F-1) * tanh(4i/depth)), Q32 integer build
	function automatic tab_t build_half_tanh();
		tab_t            tab;
		longint unsigned one;
		longint unsigned term;
		longint unsigned stp;
		longint unsigned e;
		longint unsigned num;
		longint unsigned den;
		one  = 64'd1 << 32;
		term = one;
		stp  = one;
		e    = one;
		for (int k = 1; k <= 24; k++) begin
			term = udiv64(term * 64'd8, 64'(TANH_TABLE_DEPTH) * 64'(k));
			if ((k & 1) == 1) begin
				stp = stp - term;
			end else begin
				stp = stp + term;
			end
		end
		for (int i = 0; i <= TANH_TABLE_DEPTH; i++) begin
			num    = (one - e) << (FRAC_BITS - 1);
			den    = one + e;
			tab[i] = TAB_W'(udiv64(num + (den >> 1), den));
			e      = (e * stp + (64'd1 << 31)) >> 32;
		end
		return tab;
	endfunction

	localparam tab_t HALF_TANH_TAB = build_half_tanh();

endpackage

`default_nettype wire

### rtl/rtfnc_in_if.sv
// Sample request channel: valid, ready and the input sample fields.
`default_nettype none

interface rtfnc_in_if;
	import rtfnc_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] in_sample;
	logic                          last_in_block;

	modport source (output valid, output in_sample, output last_in_block, input ready);
	modport sink   (input valid, input in_sample, input last_in_block, output ready);
endinterface

`default_nettype wire

### rtl/rtfnc_out_if.sv
// Result request channel: valid, ready and the processed sample fields.
`default_nettype none

interface rtfnc_out_if;
	import rtfnc_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] out_sample;
	logic                          saturated;

	modport source (output valid, output out_sample, output saturated, input ready);
	modport sink   (input valid, input out_sample, input saturated, output ready);
endinterface

`default_nettype wire

### rtl/rtfnc_useq.sv
// Microcode sequencer: step counter, program ROM and jump logic.
`default_nettype none

module rtfnc_useq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire rtfnc_pkg::stat_t stat,
	output rtfnc_pkg::ctrl_t    ctrl,
	output logic                in_ready
);
	import rtfnc_pkg::*;

	localparam int STEP_W = 5;
	localparam int SEQ_W  = 3;

	localparam logic [SEQ_W-1:0] SEQ_NEXT     = 3'd0;
	localparam logic [SEQ_W-1:0] SEQ_WAIT_IN  = 3'd1;
	localparam logic [SEQ_W-1:0] SEQ_JMP      = 3'd2;
	localparam logic [SEQ_W-1:0] SEQ_JTOP     = 3'd3;
	localparam logic [SEQ_W-1:0] SEQ_WAIT_OUT = 3'd4;

	localparam logic [STEP_W-1:0] ST_IDLE    = 5'd0;
	localparam logic [STEP_W-1:0] ST_LP_MUL1 = 5'd1;
	localparam logic [STEP_W-1:0] ST_LP_MUL2 = 5'd2;
	localparam logic [STEP_W-1:0] ST_LP_WB   = 5'd3;
	localparam logic [STEP_W-1:0] ST_DIFF    = 5'd4;
	localparam logic [STEP_W-1:0] ST_HP_MUL  = 5'd5;
	localparam logic [STEP_W-1:0] ST_HP_WB   = 5'd6;
	localparam logic [STEP_W-1:0] ST_NZ_MUL  = 5'd7;
	localparam logic [STEP_W-1:0] ST_NZ_WB   = 5'd8;
	localparam logic [STEP_W-1:0] ST_MAG     = 5'd9;
	localparam logic [STEP_W-1:0] ST_IDX_MUL = 5'd10;
	localparam logic [STEP_W-1:0] ST_IDX_WB  = 5'd11;
	localparam logic [STEP_W-1:0] ST_RD_LO   = 5'd12;
	localparam logic [STEP_W-1:0] ST_RD_HI   = 5'd13;
	localparam logic [STEP_W-1:0] ST_INT_MUL = 5'd14;
	localparam logic [STEP_W-1:0] ST_RD_TOP  = 5'd15;
	localparam logic [STEP_W-1:0] ST_EMIT    = 5'd16;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [SEQ_W-1:0]  seq;
		logic [STEP_W-1:0] tgt;
	} uword_t;

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_nxt;
	logic [STEP_W-1:0] step_inc;
	uword_t            uw;
	logic              go;

	// Program ROM
	always_comb begin
		case (step_q)
			ST_IDLE:    uw = '{OP_LOAD,    SEQ_WAIT_IN,  ST_IDLE};
			ST_LP_MUL1: uw = '{OP_LP_MUL1, SEQ_NEXT,     ST_IDLE};
			ST_LP_MUL2: uw = '{OP_LP_MUL2, SEQ_NEXT,     ST_IDLE};
			ST_LP_WB:   uw = '{OP_LP_WB,   SEQ_NEXT,     ST_IDLE};
			ST_DIFF:    uw = '{OP_DIFF,    SEQ_NEXT,     ST_IDLE};
			ST_HP_MUL:  uw = '{OP_HP_MUL,  SEQ_NEXT,     ST_IDLE};
			ST_HP_WB:   uw = '{OP_HP_WB,   SEQ_NEXT,     ST_IDLE};
			ST_NZ_MUL:  uw = '{OP_NZ_MUL,  SEQ_NEXT,     ST_IDLE};
			ST_NZ_WB:   uw = '{OP_NZ_WB,   SEQ_NEXT,     ST_IDLE};
			ST_MAG:     uw = '{OP_MAG,     SEQ_NEXT,     ST_IDLE};
			ST_IDX_MUL: uw = '{OP_IDX_MUL, SEQ_NEXT,     ST_IDLE};
			ST_IDX_WB:  uw = '{OP_IDX_WB,  SEQ_JTOP,     ST_RD_TOP};
			ST_RD_LO:   uw = '{OP_RD_LO,   SEQ_NEXT,     ST_IDLE};
			ST_RD_HI:   uw = '{OP_RD_HI,   SEQ_NEXT,     ST_IDLE};
			ST_INT_MUL: uw = '{OP_INT_MUL, SEQ_JMP,      ST_EMIT};
			ST_RD_TOP:  uw = '{OP_RD_TOP,  SEQ_NEXT,     ST_IDLE};
			ST_EMIT:    uw = '{OP_EMIT,    SEQ_WAIT_OUT, ST_IDLE};
			default:    uw = '{OP_NOP,     SEQ_JMP,      ST_IDLE};
		endcase
	end

	assign step_inc = step_q + STEP_W'(1);

	always_comb begin
		go       = 1'b1;
		step_nxt = step_inc;
		case (uw.seq)
			SEQ_NEXT: begin
				step_nxt = step_inc;
			end
			SEQ_WAIT_IN: begin
				go       = in_valid;
				step_nxt = in_valid ? step_inc : step_q;
			end
			SEQ_JMP: begin
				step_nxt = uw.tgt;
			end
			SEQ_JTOP: begin
				// top of table: no interpolation
				step_nxt = stat.top ? uw.tgt : step_inc;
			end
			SEQ_WAIT_OUT: begin
				go       = stat.out_free;
				step_nxt = stat.out_free ? uw.tgt : step_q;
			end
			default: begin
				step_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_nxt;
		end
	end

	assign ctrl.op  = uw.op;
	assign ctrl.en  = go;
	assign in_ready = (uw.seq == SEQ_WAIT_IN);

endmodule

`default_nettype wire

### rtl/rtfnc_dpath.sv
// Datapath: registers, shared multiplier and accumulator, rounding, clamps, LFSR, table.
`default_nettype none

module rtfnc_dpath (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    cfg_we,
	input  wire logic [rtfnc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [rtfnc_pkg::COEF_W-1:0]            cfg_data,
	input  wire logic signed [rtfnc_pkg::SAMPLE_BITS-1:0] in_sample,
	input  wire logic                                    last_in_block,
	input  wire rtfnc_pkg::ctrl_t                        ctrl,
	output rtfnc_pkg::stat_t                             stat,
	output logic signed [rtfnc_pkg::SAMPLE_BITS-1:0]     out_sample,
	output logic                                         saturated,
	output logic                                         out_valid,
	input  wire logic                                    out_ready
);
	import rtfnc_pkg::*;

	localparam logic signed [SUM_W-1:0] HALF_COEF  = SUM_W'(1) <<< (COEF_W - 1);
	localparam logic signed [SUM_W-1:0] HALF_NOISE = SUM_W'(1) <<< (NOISE_SH - 1);
	localparam logic signed [SUM_W-1:0] HALF_FRAC  = SUM_W'(1) <<< (FRAC_W - 1);
	localparam logic signed [SUM_W-1:0] ACC_MAX_S  = (SUM_W'(1) <<< (ACC_W - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] ACC_MIN_S  = ~ACC_MAX_S;
	localparam logic [MAG_W-1:0]        MAG_LIM    = MAG_W'(1) << (FRAC_BITS + 2);
	localparam logic [COEF_W:0]         ONE_COEF   = (COEF_W + 1)'(1) << COEF_W;
	localparam logic [IDX_W-1:0]        IDX_TOP    = IDX_W'(TANH_TABLE_DEPTH);
	localparam logic signed [MUL_B_W-1:0] DEPTH_B  = MUL_B_W'(TANH_TABLE_DEPTH);

	// configuration and state
	logic [COEF_W-1:0]       lp_coef_q;
	logic [COEF_W-1:0]       hp_coef_q;
	logic [COEF_W-1:0]       noise_lvl_q;
	logic [LFSR_W-1:0]       lfsr_q;
	logic signed [ACC_W-1:0] lp_q;
	logic signed [ACC_W-1:0] hp_q;
	logic                    out_valid_q;

	// working registers
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic                          last_q;
	logic                          sat_q;
	logic signed [DIFF_W-1:0]      diff_q;
	logic signed [SUM_W-1:0]       acc_q;
	logic signed [NOISE_W-1:0]     noise_q;
	logic [MAG_W-1:0]              mag_q;
	logic                          sign_q;
	logic [IDX_W-1:0]              idx_q;
	logic [FRAC_W-1:0]             frac_q;
	logic [TAB_W-1:0]              lo_q;
	logic [TAB_W-1:0]              hi_q;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;
	logic                          out_sat_q;

	// combinational
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic [COEF_W:0]           lp_coef_c;
	logic signed [LFSR_W-1:0]  lfsr_c;
	logic [TAB_W-1:0]          diff_tab;
	logic signed [SUM_W-1:0]   coef_rnd;
	logic signed [SUM_W-1:0]   noise_rnd;
	logic signed [SUM_W-1:0]   frac_rnd;
	logic signed [ACC_W-1:0]   acc_clamp;
	logic                      acc_ovf;
	logic signed [T_W-2:0]     hn_sum;
	logic signed [T_W-1:0]     t_val;
	logic [T_W-1:0]            mag_full;
	logic                      mag_clip;
	logic [IDX_W-1:0]          tab_addr;
	logic [TAB_W-1:0]          tab_rd;
	logic [TAB_W-1:0]          val;
	logic [LFSR_W-1:0]         lfsr_nxt;
	logic                      emit;

	assign lp_coef_c = ONE_COEF - {1'b0, lp_coef_q};
	// L - 2^(W-1) as two's complement: flip the top bit
	assign lfsr_c    = {~lfsr_q[LFSR_W-1], lfsr_q[LFSR_W-2:0]};
	assign diff_tab  = (hi_q >= lo_q) ? (hi_q - lo_q) : '0;

	// operand selection for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctrl.op)
			OP_LP_MUL1: begin
				mul_a = MUL_A_W'(lp_q);
				mul_b = MUL_B_W'({1'b0, lp_coef_q});
			end
			OP_LP_MUL2: begin
				mul_a = MUL_A_W'(x_q);
				mul_b = MUL_B_W'({1'b0, lp_coef_c});
			end
			OP_HP_MUL: begin
				mul_a = MUL_A_W'(diff_q);
				mul_b = MUL_B_W'({1'b0, hp_coef_q});
			end
			OP_NZ_MUL: begin
				mul_a = MUL_A_W'(lfsr_c);
				mul_b = MUL_B_W'({1'b0, noise_lvl_q});
			end
			OP_IDX_MUL: begin
				mul_a = MUL_A_W'({1'b0, mag_q});
				mul_b = DEPTH_B;
			end
			OP_INT_MUL: begin
				mul_a = MUL_A_W'({1'b0, frac_q});
				mul_b = MUL_B_W'({1'b0, diff_tab});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

	// round half up; the coefficient products are then clamped to the filter state range
	assign coef_rnd  = (acc_q + HALF_COEF) >>> COEF_W;
	assign noise_rnd = (acc_q + HALF_NOISE) >>> NOISE_SH;
	assign frac_rnd  = (acc_q + HALF_FRAC) >>> FRAC_W;

	always_comb begin
		acc_ovf   = 1'b0;
		acc_clamp = coef_rnd[ACC_W-1:0];
		if (coef_rnd > ACC_MAX_S) begin
			acc_ovf   = 1'b1;
			acc_clamp = ACC_MAX_S[ACC_W-1:0];
		end else if (coef_rnd < ACC_MIN_S) begin
			acc_ovf   = 1'b1;
			acc_clamp = ACC_MIN_S[ACC_W-1:0];
		end
	end

	assign hn_sum   = (T_W - 1)'(hp_q) + (T_W - 1)'(noise_q);
	assign t_val    = {hn_sum, 1'b0};
	assign mag_full = t_val[T_W-1] ? T_W'(-t_val) : T_W'(t_val);
	assign mag_clip = (mag_full >= T_W'(MAG_LIM));

	assign tab_addr = (ctrl.op == OP_RD_HI) ? (idx_q + IDX_W'(1)) : idx_q;
	assign tab_rd   = HALF_TANH_TAB[tab_addr];
	assign val      = lo_q + frac_rnd[TAB_W-1:0];

	assign lfsr_nxt = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);

	assign emit = ctrl.en && (ctrl.op == OP_EMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_coef_q   <= LP_COEF_RST;
			hp_coef_q   <= HP_COEF_RST;
			noise_lvl_q <= NOISE_LVL_RST;
			lfsr_q      <= NOISE_SEED_RST;
			lp_q        <= '0;
			hp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LP_COEF:    lp_coef_q   <= cfg_data;
					REG_HP_COEF:    hp_coef_q   <= cfg_data;
					REG_NOISE_LVL:  noise_lvl_q <= cfg_data;
					REG_NOISE_SEED: lfsr_q      <= cfg_data;
					default: ;
				endcase
			end else if (ctrl.en && (ctrl.op == OP_DIFF)) begin
				lfsr_q <= lfsr_nxt;
			end

			if (ctrl.en && (ctrl.op == OP_LP_WB)) begin
				lp_q <= acc_clamp;
			end else if (emit && last_q) begin
				lp_q <= '0;
			end

			if (ctrl.en && (ctrl.op == OP_HP_WB)) begin
				hp_q <= acc_clamp;
			end else if (emit && last_q) begin
				hp_q <= '0;
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			case (ctrl.op)
				OP_LOAD: begin
					x_q    <= in_sample;
					last_q <= last_in_block;
					sat_q  <= 1'b0;
				end
				OP_LP_MUL1, OP_HP_MUL, OP_NZ_MUL, OP_IDX_MUL, OP_INT_MUL: begin
					acc_q <= SUM_W'(prod);
				end
				OP_LP_MUL2: begin
					acc_q <= acc_q + SUM_W'(prod);
				end
				OP_LP_WB, OP_HP_WB: begin
					sat_q <= sat_q | acc_ovf;
				end
				OP_DIFF: begin
					diff_q <= DIFF_W'(hp_q) + DIFF_W'(x_q) - DIFF_W'(lp_q);
				end
				OP_NZ_WB: begin
					noise_q <= noise_rnd[NOISE_W-1:0];
				end
				OP_MAG: begin
					sign_q <= t_val[T_W-1];
					mag_q  <= mag_clip ? MAG_LIM : mag_full[MAG_W-1:0];
					sat_q  <= sat_q | mag_clip;
				end
				OP_IDX_WB: begin
					idx_q  <= acc_q[FRAC_W +: IDX_W];
					frac_q <= acc_q[FRAC_W-1:0];
				end
				OP_RD_LO: begin
					lo_q <= tab_rd;
				end
				OP_RD_HI: begin
					hi_q <= tab_rd;
				end
				OP_RD_TOP: begin
					lo_q  <= tab_rd;
					acc_q <= '0;
				end
				OP_EMIT: begin
					out_sample_q <= sign_q ? -SAMPLE_BITS'(val) : SAMPLE_BITS'(val);
					out_sat_q    <= sat_q;
				end
				default: ;
			endcase
		end
	end

	// product bits above the fraction give the table interval
	assign stat.top      = (acc_q[FRAC_W +: IDX_W] >= IDX_TOP);
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_sample = out_sample_q;
	assign saturated  = out_sat_q;
	assign out_valid  = out_valid_q;

endmodule

`default_nettype wire

### rtl/radio_tone_filter_noise_clip.sv
// Top level of the radio tone block: lowpass, leaky highpass, LFSR noise, tanh soft clip.
//
//  channel   dir  handshake          payload
//  sample    in   valid / ready      in_sample, last_in_block
//  result    out  valid / ready      out_sample, saturated
//  cfg       in   cfg_we (no ready)  cfg_index, cfg_data
//
// A sample is taken only in the sequencer's idle step; the result reaches the output
// register through the remaining microcode steps, without the interpolation steps when
// the table argument reaches the top entry. Every product takes one microcode step on the
// single shared multiplier. Once a result is emitted, its output register lets the next
// sample be taken while it waits; a stalled result holds the sequencer at its final step.
// Reset loads the register defaults and clears both filter states; no clearing pass.
`default_nettype none

module radio_tone_filter_noise_clip (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [rtfnc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rtfnc_pkg::COEF_W-1:0]      cfg_data,
	rtfnc_in_if.sink                               sample,
	rtfnc_out_if.source                            result
);
	import rtfnc_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	rtfnc_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.stat     (stat),
		.ctrl     (ctrl),
		.in_ready (sample.ready)
	);

	rtfnc_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_sample     (sample.in_sample),
		.last_in_block (sample.last_in_block),
		.ctrl          (ctrl),
		.stat          (stat),
		.out_sample    (result.out_sample),
		.saturated     (result.saturated),
		.out_valid     (result.valid),
		.out_ready     (result.ready)
	);

endmodule

`default_nettype wire
